FILE: rtl/aes_encrypt_programmable_sbox_macros.svh
// assertion helpers for the cipher block
`ifndef AES_ENCRYPT_PROGRAMMABLE_SBOX_MACROS_SVH
`define AES_ENCRYPT_PROGRAMMABLE_SBOX_MACROS_SVH

// same-cycle implication
`define AESPS_ASSERT_IMPL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AESPS_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/aesps_pkg.sv
package aesps_pkg;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_ENC  = 1'b1;

  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic [63:0] key_part0;
    logic [63:0] key_part1;
    logic [63:0] key_part2;
    logic [63:0] key_part3;
  } in_req_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_res_t;

  // one classified request waiting for the engine
  typedef struct packed {
    logic         enc;
    logic [7:0]   idx;
    logic [7:0]   val;
    logic [127:0] plain;
    logic [255:0] key;
  } entry_t;

endpackage

FILE: rtl/aes_encrypt_programmable_sbox.sv
// channel   direction  handshake           payload
// in        input      in_valid/in_stall   aesps_pkg::in_req_t
// out       output     out_valid/out_stall aesps_pkg::out_res_t
// cfg       input      cfg_we              cfg_wdata (key size mode)
//
// a table load is written into the table as it leaves the two-entry queue
// an encrypt builds its round keys one word at a time; a key word that needs the
// substitution table waits on the single table read port, as does each round's SubBytes
// synchronous active-low reset clears control and sets 128-bit mode; the table is not cleared
// the queue keeps taking requests while a result waits on out_stall, until the queue is full
`include "aes_encrypt_programmable_sbox_macros.svh"

module aes_encrypt_programmable_sbox (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aesps_pkg::in_req_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aesps_pkg::out_res_t  out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata
);

  logic              q_valid;
  logic              q_pop;
  aesps_pkg::entry_t q_entry;

  aesps_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  aesps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `AESPS_ASSERT_IMPL(a_pop_needs_entry, clk, q_pop, q_valid, "pop from empty queue")
  `AESPS_ASSERT_NEXT(a_one_result, clk, out_valid && !out_stall, !out_valid, "result repeated")
  `AESPS_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid && !q_valid, "activity after reset")

endmodule

FILE: rtl/aesps_front.sv
module aesps_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aesps_pkg::in_req_t  in_data,
  output logic                q_valid,
  output aesps_pkg::entry_t   q_entry,
  input  logic                q_pop
);

  aesps_pkg::entry_t q_mem [aesps_pkg::QDEPTH];
  logic [aesps_pkg::QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [aesps_pkg::QAW:0]   cnt_r, cnt_nxt;
  aesps_pkg::entry_t         ent;
  logic                      push;

  always_comb begin
    ent.enc   = (in_data.req_type == aesps_pkg::REQ_ENC);
    ent.idx   = in_data.table_index;
    ent.val   = in_data.table_value;
    ent.plain = {in_data.plain_hi, in_data.plain_lo};
    ent.key   = {in_data.key_part0, in_data.key_part1, in_data.key_part2, in_data.key_part3};
  end

  assign in_stall = (cnt_r == (aesps_pkg::QAW+1)'(aesps_pkg::QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = q_mem[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = q_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= ent;
    end
  end

endmodule

FILE: rtl/aesps_back.sv
module aesps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  logic                 q_valid,
  input  aesps_pkg::entry_t    q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aesps_pkg::out_res_t  out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_KSUB = 3'd2;
  localparam logic [2:0] S_SSUB = 3'd3;
  localparam logic [2:0] S_COMB = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  function automatic logic [7:0] gf_dbl(input logic [7:0] b);
    gf_dbl = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] d [4];
    logic [31:0] o;
    for (int r = 0; r < 4; r++) begin
      a[r] = c[31-8*r -: 8];
      d[r] = gf_dbl(a[r]);
    end
    o = '0;
    for (int r = 0; r < 4; r++) begin
      o[31-8*r -: 8] = d[r] ^ d[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
    end
    mix_col = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-32*c-8*r -: 8] = s[127-32*((c+r)%4)-8*r -: 8];
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] k);
    case (k)
      4'd0:    rcon = 8'h01;
      4'd1:    rcon = 8'h02;
      4'd2:    rcon = 8'h04;
      4'd3:    rcon = 8'h08;
      4'd4:    rcon = 8'h10;
      4'd5:    rcon = 8'h20;
      4'd6:    rcon = 8'h40;
      4'd7:    rcon = 8'h80;
      4'd8:    rcon = 8'h1b;
      4'd9:    rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  endfunction

  logic [7:0]   mem [256];
  logic [7:0]   rdata_r;
  logic [7:0]   raddr;
  logic         mem_we;

  logic [2:0]   state_r, state_nxt;
  logic [1:0]   mode_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] sb_r, sb_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [31:0]  win_r [8];
  logic [31:0]  win_nxt [8];
  logic [31:0]  ksrc_r, ksrc_nxt;
  logic [23:0]  ktmp_r, ktmp_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic [5:0]   i_r, i_nxt;
  logic [2:0]   j_r, j_nxt;
  logic [3:0]   rc_r, rc_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [1:0]   rkc_r, rkc_nxt;

  logic [3:0]   nk, nr, kidx4, base4;
  logic [2:0]   kidx, base;
  logic [31:0]  word_new, sub_t;
  logic         word_done, win_shift;
  logic [127:0] rk_new, sr, mc;
  logic [7:0]   st_b [16];
  logic [7:0]   ks_b [4];

  always_comb begin
    case (mode_r)
      aesps_pkg::MODE_192: begin
        nk = 4'd6;
        nr = 4'd12;
      end
      aesps_pkg::MODE_256: begin
        nk = 4'd8;
        nr = 4'd14;
      end
      default: begin
        nk = 4'd4;
        nr = 4'd10;
      end
    endcase
  end

  assign base4 = 4'd8 - nk;
  assign base  = base4[2:0];
  assign kidx4 = base4 + {1'b0, i_r[2:0]};
  assign kidx  = kidx4[2:0];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      st_b[k] = st_r[127-8*k -: 8];
    end
    for (int k = 0; k < 4; k++) begin
      ks_b[k] = ksrc_r[31-8*k -: 8];
    end
  end

  assign sr = shift_rows(sb_r);
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mc[127-32*c -: 32] = mix_col(sr[127-32*c -: 32]);
    end
  end

  assign sub_t = {ktmp_r, rdata_r} ^ ((j_r == 3'd0) ? {rcon(rc_r), 24'h0} : 32'h0);

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    sb_nxt    = sb_r;
    rk_nxt    = rk_r;
    ksrc_nxt  = ksrc_r;
    ktmp_nxt  = ktmp_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    rc_nxt    = rc_r;
    rnd_nxt   = rnd_r;
    rkc_nxt   = rkc_r;
    for (int k = 0; k < 8; k++) begin
      win_nxt[k] = win_r[k];
    end
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    raddr     = ks_b[cnt_r[1:0]];
    word_done = 1'b0;
    win_shift = 1'b0;
    word_new  = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_entry.enc) begin
            mem_we = 1'b1;
          end else begin
            st_nxt  = q_entry.plain;
            i_nxt   = '0;
            j_nxt   = '0;
            rc_nxt  = '0;
            rnd_nxt = '0;
            rkc_nxt = '0;
            // place key words so that the newest sits at the top of the window
            for (int k = 0; k < 8; k++) begin
              win_nxt[k] = q_entry.key[255-32*k -: 32];
            end
            if (mode_r == aesps_pkg::MODE_192) begin
              for (int k = 2; k < 8; k++) begin
                win_nxt[k] = q_entry.key[255-32*(k-2) -: 32];
              end
            end else if (mode_r != aesps_pkg::MODE_256) begin
              for (int k = 4; k < 8; k++) begin
                win_nxt[k] = q_entry.key[255-32*(k-4) -: 32];
              end
            end
            state_nxt = S_KEY;
          end
        end
      end
      S_KEY: begin
        if ({2'b00, i_r} < {4'b0000, nk}) begin
          word_new  = win_r[kidx];
          word_done = 1'b1;
        end else if (j_r == 3'd0 || (nk == 4'd8 && j_r == 3'd4)) begin
          ksrc_nxt  = (j_r == 3'd0) ? {win_r[7][23:0], win_r[7][31:24]} : win_r[7];
          cnt_nxt   = '0;
          state_nxt = S_KSUB;
        end else begin
          word_new  = win_r[base] ^ win_r[7];
          word_done = 1'b1;
          win_shift = 1'b1;
        end
      end
      S_KSUB: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          ktmp_nxt = {ktmp_r[15:0], rdata_r};
        end
        if (cnt_r == 5'd4) begin
          word_new  = win_r[base] ^ sub_t;
          word_done = 1'b1;
          win_shift = 1'b1;
          state_nxt = S_KEY;
          if (j_r == 3'd0) begin
            rc_nxt = rc_r + 1'b1;
          end
        end
      end
      S_SSUB: begin
        raddr   = st_b[cnt_r[3:0]];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          sb_nxt = {sb_r[119:0], rdata_r};
        end
        if (cnt_r == 5'd16) begin
          state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        st_nxt = ((rnd_r == nr) ? sr : mc) ^ rk_r;
        if (rnd_r == nr) begin
          state_nxt = S_DONE;
        end else begin
          rnd_nxt   = rnd_r + 1'b1;
          state_nxt = S_KEY;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    rk_new = {rk_r[95:0], word_new};
    if (word_done) begin
      i_nxt   = i_r + 1'b1;
      j_nxt   = ({1'b0, j_r} == nk - 4'd1) ? 3'd0 : j_r + 1'b1;
      rk_nxt  = rk_new;
      rkc_nxt = rkc_r + 1'b1;
      if (win_shift) begin
        for (int k = 0; k < 7; k++) begin
          win_nxt[k] = win_r[k+1];
        end
        win_nxt[7] = word_new;
      end
      if (rkc_r == 2'd3) begin
        if (rnd_r == 4'd0) begin
          // initial key addition
          st_nxt    = st_r ^ rk_new;
          rnd_nxt   = 4'd1;
          state_nxt = S_KEY;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_SSUB;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= aesps_pkg::MODE_128;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    sb_r   <= sb_nxt;
    rk_r   <= rk_nxt;
    ksrc_r <= ksrc_nxt;
    ktmp_r <= ktmp_nxt;
    cnt_r  <= cnt_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    rc_r   <= rc_nxt;
    rnd_r  <= rnd_nxt;
    rkc_r  <= rkc_nxt;
    for (int k = 0; k < 8; k++) begin
      win_r[k] <= win_nxt[k];
    end
  end

  // substitution table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_entry.idx] <= q_entry.val;
    end
    rdata_r <= mem[raddr];
  end

  assign out_valid          = (state_r == S_DONE);
  assign out_data.cipher_hi = st_r[127:64];
  assign out_data.cipher_lo = st_r[63:0];

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // expected ciphertexts and the block's table/mode as seen from outside
  class cipher_scoreboard;
    logic [7:0] subst [256];
    logic [1:0] key_mode;
    aesps_pkg::out_res_t cipher_q[$];
    int         errors;
    int         checked;

    function new();
      key_mode = aesps_pkg::MODE_128;
      errors   = 0;
      checked  = 0;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on result %0d: %s got %h want %h", checked, what, got, want);
      errors++;
    endtask

    function logic [31:0] sub_word(logic [31:0] w);
      return {subst[w[31:24]], subst[w[23:16]], subst[w[15:8]], subst[w[7:0]]};
    endfunction

    function logic [7:0] gf_dbl(logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function logic [31:0] mix_column(logic [31:0] c);
      logic [7:0] a [4];
      logic [7:0] d [4];
      logic [31:0] o;
      for (int r = 0; r < 4; r++) begin
        a[r] = c[31-8*r -: 8];
        d[r] = gf_dbl(a[r]);
      end
      for (int r = 0; r < 4; r++)
        o[31-8*r -: 8] = d[r] ^ d[(r+1)%4] ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      return o;
    endfunction

    function aesps_pkg::out_res_t encrypt_block(aesps_pkg::in_req_t r);
      logic [31:0] w [60];
      logic [31:0] col [4];
      logic [31:0] sh [4];
      logic [63:0] kp [4];
      logic [31:0] t;
      logic [7:0]  rc;
      int nk, nr, total;
      aesps_pkg::out_res_t res;
      kp = '{r.key_part0, r.key_part1, r.key_part2, r.key_part3};
      case (key_mode)
        aesps_pkg::MODE_192: begin nk = 6; nr = 12; end
        aesps_pkg::MODE_256: begin nk = 8; nr = 14; end
        default:  begin nk = 4; nr = 10; end
      endcase
      total = 4 * (nr + 1);
      for (int i = 0; i < 8; i++)
        w[i] = (i % 2) ? kp[i/2][31:0] : kp[i/2][63:32];
      for (int i = nk; i < total; i++) begin
        t = w[i-1];
        if (i % nk == 0) begin
          rc = 8'h01;
          repeat (((i / nk) - 1) % 10) rc = gf_dbl(rc);
          t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        end else if (nk > 6 && i % nk == 4) begin
          t = sub_word(t);
        end
        w[i] = w[i-nk] ^ t;
      end
      col = '{r.plain_hi[63:32], r.plain_hi[31:0], r.plain_lo[63:32], r.plain_lo[31:0]};
      for (int c = 0; c < 4; c++) col[c] ^= w[c];
      for (int rnd = 1; rnd <= nr; rnd++) begin
        for (int c = 0; c < 4; c++) col[c] = sub_word(col[c]);
        for (int c = 0; c < 4; c++)
          for (int b = 0; b < 4; b++)
            sh[c][31-8*b -: 8] = col[(c+b)%4][31-8*b -: 8];
        for (int c = 0; c < 4; c++)
          col[c] = (rnd != nr) ? mix_column(sh[c]) : sh[c];
        for (int c = 0; c < 4; c++) col[c] ^= w[4*rnd+c];
      end
      res.cipher_hi = {col[0], col[1]};
      res.cipher_lo = {col[2], col[3]};
      return res;
    endfunction

    function void note_request(aesps_pkg::in_req_t r);
      if (r.req_type == aesps_pkg::REQ_LOAD)
        subst[r.table_index] = r.table_value;
      else
        cipher_q.push_back(encrypt_block(r));
    endfunction

    task check_result(aesps_pkg::out_res_t got);
      aesps_pkg::out_res_t want;
      if (cipher_q.size() == 0) begin
        report_mismatch("unexpected result", got.cipher_hi, 64'h0);
      end else begin
        want = cipher_q.pop_front();
        if (got.cipher_hi !== want.cipher_hi)
          report_mismatch("cipher_hi", got.cipher_hi, want.cipher_hi);
        if (got.cipher_lo !== want.cipher_lo)
          report_mismatch("cipher_lo", got.cipher_lo, want.cipher_lo);
      end
      checked++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  aesps_pkg::in_req_t  in_data;
  logic     out_valid;
  logic     out_stall;
  aesps_pkg::out_res_t out_data;
  logic     cfg_we;
  logic [1:0] cfg_wdata;

  cipher_scoreboard sb;
  int  burst_left;
  bit  long_hold;
  int  sent_loads, sent_encrypts;

  aes_encrypt_programmable_sbox DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #36ms;
    $display("timeout with %0d results outstanding", sb.cipher_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: stall pattern in segments, plus one long hold on request
  initial begin
    int seg, pct;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (1500) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        seg = $urandom_range(4, 60);
        case ($urandom_range(0, 3))
          0: pct = 0;
          1: pct = 25;
          2: pct = 60;
          default: pct = 90;
        endcase
        repeat (seg) begin
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  task send_request(aesps_pkg::in_req_t r);
    int gap;
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    if (r.req_type == aesps_pkg::REQ_LOAD) sent_loads++;
    else sent_encrypts++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function aesps_pkg::in_req_t make_request(logic kind);
    aesps_pkg::in_req_t r;
    r.req_type    = kind;
    r.table_index = 8'($urandom);
    r.table_value = 8'($urandom);
    r.plain_hi    = {$urandom, $urandom};
    r.plain_lo    = {$urandom, $urandom};
    r.key_part0   = {$urandom, $urandom};
    r.key_part1   = {$urandom, $urandom};
    r.key_part2   = {$urandom, $urandom};
    r.key_part3   = {$urandom, $urandom};
    return r;
  endfunction

  function aesps_pkg::in_req_t make_encrypt(logic [63:0] pt, logic [63:0] key);
    aesps_pkg::in_req_t r;
    r = make_request(aesps_pkg::REQ_ENC);
    r.plain_hi  = pt;
    r.plain_lo  = pt;
    r.key_part0 = key;
    r.key_part1 = key;
    r.key_part2 = key;
    r.key_part3 = key;
    return r;
  endfunction

  // loads leave no result behind, so give the engine time to drain them too
  task wait_idle();
    while (sb.cipher_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_key_mode(logic [1:0] m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.key_mode = m;
    @(posedge clk);
  endtask

  task run_random(int n, int enc_pct);
    aesps_pkg::in_req_t r;
    for (int k = 0; k < n; k++) begin
      r = make_request(($urandom_range(0, 99) < enc_pct) ? aesps_pkg::REQ_ENC
                                                         : aesps_pkg::REQ_LOAD);
      send_request(r);
    end
    drop_valid();
  endtask

  initial begin
    aesps_pkg::in_req_t r;
    logic [1:0] modes [6];
    sb = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = aesps_pkg::MODE_128;
    long_hold = 1'b0;
    burst_left = 4;
    sent_loads = 0;
    sent_encrypts = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill every table entry before any encrypt reads it
    for (int i = 0; i < 256; i++) begin
      r = make_request(aesps_pkg::REQ_LOAD);
      r.table_index = 8'(i);
      if (i == 0) r.table_value = 8'h00;
      else if (i == 255) r.table_value = 8'hff;
      send_request(r);
    end
    drop_valid();

    // extremes in every key size, mode three included
    for (int m = 0; m < 4; m++) begin
      write_key_mode(2'(m));
      send_request(make_encrypt('0, '0));
      send_request(make_encrypt('1, '1));
      send_request(make_encrypt('1, '0));
      send_request(make_request(aesps_pkg::REQ_ENC));
      drop_valid();
    end
    r = make_request(aesps_pkg::REQ_LOAD);
    r.table_index = 8'hff;
    r.table_value = 8'h00;
    send_request(r);
    send_request(make_encrypt('0, '1));
    drop_valid();

    // long receiver hold while requests keep coming, so the input backs up
    write_key_mode(aesps_pkg::MODE_256);
    long_hold = 1'b1;
    for (int k = 0; k < 8; k++) send_request(make_request(aesps_pkg::REQ_ENC));
    drop_valid();
    wait_idle();

    modes = '{aesps_pkg::MODE_128, aesps_pkg::MODE_256, aesps_pkg::MODE_192, 2'd3,
              aesps_pkg::MODE_128, aesps_pkg::MODE_192};
    foreach (modes[p]) begin
      write_key_mode(modes[p]);
      run_random(110, 35);
      // sender holds back until all ciphertexts are out
      while (sb.cipher_q.size() != 0) @(posedge clk);
      run_random(110, 35);
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("covered %0d table loads and %0d encrypts over all key sizes",
             sent_loads, sent_encrypts);
    $display("with random sender gaps, receiver stalls and a long output hold");
    if (sb.errors == 0 && sb.cipher_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/aesps_pkg.sv
rtl/aesps_front.sv
rtl/aesps_back.sv
rtl/aes_encrypt_programmable_sbox.sv
bench/tb_top.sv
